// File: src/mpc_pkg.sv
package mpc_pkg;

	localparam int MAX_DIM_DEF = 4096;
	localparam int FRAC_BITS_DEF = 28;

	localparam logic [2:0] REG_WIDTH = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_ASPECT = 3'd2;
	localparam logic [2:0] REG_ZOOM = 3'd3;
	localparam logic [2:0] REG_ESCAPE = 3'd4;
	localparam logic [2:0] REG_CLIMIT = 3'd5;

	typedef struct packed {
		logic [12:0] pixel_x;
		logic [12:0] pixel_y;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [6:0] iteration_count;
		logic in_set;
	} pix_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVX,
		ST_DIVY,
		ST_CRE1,
		ST_CRE2,
		ST_CIM,
		ST_ITER,
		ST_PDIV,
		ST_PAL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_sel_y;
		logic cre1;
		logic cre2;
		logic cim;
		logic iter_init;
		logic iter_step;
		logic pal_start;
		logic pal_fin;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic iter_done;
		logic pal_done;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

// File: src/mandelbrot_pixel_colour.sv
// Mandelbrot escape-time pixel colour. One item (1-based pixel_x, pixel_y) is handled at a
// time: after it is accepted come the two bit-serial coordinate divides, the scaling states
// CRE1, CRE2 and CIM, the escape-time loop at one iteration per cycle (up to colour_limit-1
// iterations) followed by the final escape test, then the palette work, which finds seg (at
// most 7) by subtracting colour_limit from 7*count and then the colour quotients (at most
// 255) by repeated subtraction, and a final state that registers the colour. The result
// waits in an output register until taken; the next item can be accepted in the cycle after
// the result leaves. Configure only while idle.
module mandelbrot_pixel_colour #(
	parameter int FRAC_BITS = mpc_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  mpc_pkg::pix_in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output mpc_pkg::pix_out_t out_data,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);

	mpc_pkg::cmd_t cmd;
	mpc_pkg::sts_t sts;

	mpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

	mpc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix_in(in_data), .cmd(cmd), .sts(sts), .pix_out(out_data)
	);

endmodule

// File: src/mpc_ctrl.sv
module mpc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output mpc_pkg::cmd_t cmd,
	input  mpc_pkg::sts_t sts
);

	mpc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mpc_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			mpc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.div_start = 1'b1;
					state_d = mpc_pkg::ST_DIVX;
				end
			end
			mpc_pkg::ST_DIVX: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel_y = 1'b1;
					state_d = mpc_pkg::ST_DIVY;
				end
			end
			mpc_pkg::ST_DIVY: begin
				cmd.div_sel_y = 1'b1;
				if (sts.div_done) state_d = mpc_pkg::ST_CRE1;
			end
			mpc_pkg::ST_CRE1: begin
				cmd.cre1 = 1'b1;
				state_d = mpc_pkg::ST_CRE2;
			end
			mpc_pkg::ST_CRE2: begin
				cmd.cre2 = 1'b1;
				state_d = mpc_pkg::ST_CIM;
			end
			mpc_pkg::ST_CIM: begin
				cmd.cim = 1'b1;
				cmd.iter_init = 1'b1;
				state_d = mpc_pkg::ST_ITER;
			end
			mpc_pkg::ST_ITER: begin
				if (sts.iter_done) begin
					cmd.pal_start = 1'b1;
					state_d = mpc_pkg::ST_PDIV;
				end else cmd.iter_step = 1'b1;
			end
			mpc_pkg::ST_PDIV: begin
				if (sts.pal_done) state_d = mpc_pkg::ST_PAL;
			end
			mpc_pkg::ST_PAL: begin
				cmd.pal_fin = 1'b1;
				state_d = mpc_pkg::ST_OUT;
			end
			mpc_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = mpc_pkg::ST_IDLE;
			end
			default: state_d = mpc_pkg::ST_IDLE;
		endcase
	end

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_retire: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> (state_q == mpc_pkg::ST_IDLE)) else $error("result not retired");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == mpc_pkg::ST_DIVX)) else $error("no start");
	a_pal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pal_fin |=> out_valid) else $error("no result after palette");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");

endmodule

// File: src/mpc_datapath.sv
module mpc_datapath #(
	parameter int FRAC_BITS = mpc_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  mpc_pkg::pix_in_t pix_in,
	input  mpc_pkg::cmd_t cmd,
	output mpc_pkg::sts_t sts,
	output mpc_pkg::pix_out_t pix_out
);

	// quotient bits: (p-1)<<F over dim-1; numerator magnitude below 2^(13+F)
	localparam int NB = 13 + FRAC_BITS + 1;
	localparam int DW = $clog2(NB + 1);
	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
	localparam logic [31:0] HALF = 32'd1 << (FRAC_BITS - 1);

	logic [12:0] width_q, height_q;
	logic [31:0] aspect_q, zoom_q, escape_q;
	logic [6:0] climit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 13'd1200;
			height_q <= 13'd800;
			aspect_q <= 32'd25165824;
			zoom_q <= 32'd25165824;
			escape_q <= 32'd50331648;
			climit_q <= 7'd40;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mpc_pkg::REG_WIDTH: width_q <= cfg_data[12:0];
				mpc_pkg::REG_HEIGHT: height_q <= cfg_data[12:0];
				mpc_pkg::REG_ASPECT: aspect_q <= cfg_data;
				mpc_pkg::REG_ZOOM: zoom_q <= cfg_data;
				mpc_pkg::REG_ESCAPE: escape_q <= cfg_data;
				mpc_pkg::REG_CLIMIT: climit_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// x divide starts on the accepting cycle, straight from the item
	logic [12:0] py_q;
	always_ff @(posedge clk) if (cmd.load) begin
		py_q <= pix_in.pixel_y;
	end

	// restoring divider, one quotient bit a cycle, on magnitudes
	logic [NB-1:0] num_q, quo_q;
	logic [13:0] rem_q;
	logic [12:0] den_q;
	logic [DW-1:0] cnt_q;
	logic busy_q, neg_q, zero_q, sel_q;
	logic [13:0] p_m1;
	logic [12:0] dim;
	logic [14:0] trial;
	always_comb begin
		p_m1 = cmd.div_sel_y ? ({1'b0, py_q} - 14'd1) : ({1'b0, pix_in.pixel_x} - 14'd1);
		dim = cmd.div_sel_y ? height_q : width_q;
		trial = {rem_q, num_q[NB-1]} - {2'b0, den_q};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) busy_q <= 1'b0;
		else if (cmd.div_start) busy_q <= 1'b1;
		else if (busy_q && cnt_q == DW'(NB - 1)) busy_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			sel_q <= cmd.div_sel_y;
			neg_q <= p_m1[13];
			zero_q <= dim < 13'd2;
			num_q <= NB'(p_m1[13] ? 14'd1 : p_m1) << FRAC_BITS;
			den_q <= dim - 13'd1;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			cnt_q <= cnt_q + DW'(1);
			if (!trial[14]) begin
				rem_q <= trial[13:0];
				quo_q <= {quo_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[12:0], num_q[NB-1]};
				quo_q <= {quo_q[NB-2:0], 1'b0};
			end
		end
	end
	assign sts.div_done = busy_q && cnt_q == DW'(NB - 1);

	logic [NB-1:0] qfin;
	logic signed [31:0] frac;
	always_comb begin
		qfin = {quo_q[NB-2:0], !trial[14]};
		if (zero_q) frac = '0;
		else if (neg_q) frac = mpc_pkg::sat32(-66'($signed({2'b0, qfin})));
		else frac = mpc_pkg::sat32(66'($signed({2'b0, qfin})));
	end
	logic signed [31:0] fx_q, fy_q;
	always_ff @(posedge clk) if (sts.div_done) begin
		if (sel_q) fy_q <= frac;
		else fx_q <= frac;
	end

	// signed multiply with truncation toward zero on magnitude
	function automatic logic signed [65:0] mshift(input logic signed [32:0] a,
		input logic signed [32:0] b, input int sh);
		logic [32:0] ma, mb;
		logic [65:0] p;
		ma = a[32] ? -a : a;
		mb = b[32] ? -b : b;
		p = ({33'b0, ma} * {33'b0, mb}) >> sh;
		return (a[32] ^ b[32]) ? -$signed(p) : $signed(p);
	endfunction

	logic signed [31:0] cre_q, cim_q;
	always_ff @(posedge clk) begin
		if (cmd.cre1)
			cre_q <= mpc_pkg::sat32(mshift($signed({1'b0, aspect_q}), 33'(fx_q), 24)
				- $signed({34'b0, ONE}));
		if (cmd.cre2)
			cre_q <= mpc_pkg::sat32(mshift($signed({1'b0, zoom_q}), 33'(cre_q), 24));
		if (cmd.cre1)
			cim_q <= mpc_pkg::sat32($signed({34'b0, HALF}) - 66'(fy_q));
		if (cmd.cim)
			cim_q <= mpc_pkg::sat32(mshift($signed({1'b0, zoom_q}), 33'(cim_q), 24));
	end

	// escape-time loop: one iteration per cycle
	logic signed [31:0] re_q, im_q;
	logic [64:0] quad_q;
	logic [6:0] n_q;
	logic [63:0] lim;
	logic [31:0] mre, mim;
	logic [64:0] qnext;
	always_comb begin
		if (FRAC_BITS >= 24) lim = {32'b0, escape_q} << (FRAC_BITS - 24);
		else lim = {32'b0, escape_q} >> (24 - FRAC_BITS);
		mre = re_q[31] ? -re_q : re_q;
		mim = im_q[31] ? -im_q : im_q;
		qnext = (({33'b0, mre} * {33'b0, mre}) + ({33'b0, mim} * {33'b0, mim})) >> FRAC_BITS;
	end
	assign sts.iter_done = !(n_q < climit_q && quad_q < {1'b0, lim});
	always_ff @(posedge clk) begin
		if (cmd.iter_init) begin
			re_q <= '0;
			im_q <= '0;
			quad_q <= '0;
			n_q <= 7'd1;
		end else if (cmd.iter_step) begin
			re_q <= mpc_pkg::sat32(mshift(33'(re_q), 33'(re_q), FRAC_BITS)
				- mshift(33'(im_q), 33'(im_q), FRAC_BITS) + 66'(cre_q));
			im_q <= mpc_pkg::sat32(mshift(33'(re_q), 33'(im_q), FRAC_BITS - 1) + 66'(cim_q));
			quad_q <= qnext;
			n_q <= n_q + 7'd1;
		end
	end

	// palette: 7n / L by repeated subtraction, then k*r/L products likewise
	logic [9:0] pr_q;
	logic [2:0] seg_q;
	logic [15:0] a_q, b_q;
	logic [7:0] qa_q, qb_q;
	logic [1:0] ph_q;
	logic pbusy_q;
	logic [6:0] rem7, qn7;
	logic [7:0] ka, kb;
	logic [7:0] ca, cb;
	always_comb begin
		rem7 = pr_q[6:0];
		qn7 = climit_q - rem7;
		ka = 8'd0; kb = 8'd0; ca = 8'd0; cb = 8'd0;
		case (seg_q)
			3'd0: begin ka = 8'd255; ca = {1'b0, rem7}; kb = 8'd127; cb = {1'b0, rem7}; end
			3'd1: begin ka = 8'd255; ca = {1'b0, rem7}; end
			3'd2: begin ka = 8'd255; ca = {1'b0, qn7}; end
			3'd3: begin ka = 8'd127; ca = {1'b0, qn7}; end
			3'd4: begin ka = 8'd127; ca = {1'b0, qn7}; kb = 8'd63; cb = {1'b0, qn7}; end
			3'd5: begin ka = 8'd128; ca = {1'b0, rem7}; end
			3'd6: begin ka = 8'd128; ca = {1'b0, qn7}; kb = 8'd64; cb = {1'b0, qn7}; end
			default: ;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pbusy_q <= 1'b0;
		else if (cmd.pal_start) pbusy_q <= 1'b1;
		else if (sts.pal_done) pbusy_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.pal_start) begin
			pr_q <= 10'd7 * {3'b0, n_q};
			seg_q <= '0;
			ph_q <= 2'd0;
		end else if (pbusy_q) begin
			if (ph_q == 2'd0) begin
				if (climit_q != 7'd0 && pr_q >= {3'b0, climit_q} && seg_q != 3'd7) begin
					pr_q <= pr_q - {3'b0, climit_q};
					seg_q <= seg_q + 3'd1;
				end else ph_q <= 2'd1;
			end else if (ph_q == 2'd1) begin
				a_q <= 16'(ka) * 16'(ca);
				b_q <= 16'(kb) * 16'(cb);
				qa_q <= '0;
				qb_q <= '0;
				ph_q <= 2'd2;
			end else if (ph_q == 2'd2) begin
				if (climit_q != 7'd0 && a_q >= {9'b0, climit_q}) begin
					a_q <= a_q - {9'b0, climit_q};
					qa_q <= qa_q + 8'd1;
				end
				if (climit_q != 7'd0 && b_q >= {9'b0, climit_q}) begin
					b_q <= b_q - {9'b0, climit_q};
					qb_q <= qb_q + 8'd1;
				end
				if (climit_q == 7'd0 || (a_q < {9'b0, climit_q} && b_q < {9'b0, climit_q}))
					ph_q <= 2'd3;
			end
		end
	end
	assign sts.pal_done = pbusy_q && ph_q == 2'd3;

	logic black;
	assign black = n_q == climit_q;
	always_ff @(posedge clk) if (cmd.pal_fin) begin
		pix_out.iteration_count <= n_q;
		pix_out.in_set <= black;
		pix_out.red <= '0;
		pix_out.green <= '0;
		pix_out.blue <= '0;
		if (!black && climit_q != 7'd0) begin
			case (seg_q)
				3'd0: begin
					pix_out.green <= qa_q; pix_out.blue <= qb_q + 8'd128;
				end
				3'd1: begin
					pix_out.red <= qa_q; pix_out.green <= 8'd255; pix_out.blue <= 8'd255;
				end
				3'd2: begin
					pix_out.red <= 8'd255; pix_out.green <= 8'd255; pix_out.blue <= qa_q;
				end
				3'd3: begin
					pix_out.red <= 8'd255; pix_out.green <= qa_q + 8'd128;
				end
				3'd4: begin
					pix_out.red <= qa_q + 8'd128; pix_out.green <= qb_q + 8'd64;
				end
				3'd5: begin
					pix_out.red <= 8'd128; pix_out.green <= 8'd64; pix_out.blue <= qa_q;
				end
				3'd6: begin
					pix_out.red <= qa_q; pix_out.green <= qb_q; pix_out.blue <= 8'd128;
				end
				default: ;
			endcase
		end
	end

	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> busy_q) else $error("divider not started");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.iter_step |=> n_q == $past(n_q) + 7'd1) else $error("count slip");
	a_pal: assert property (@(posedge clk) disable iff (!arst_n)
		sts.pal_done |-> pbusy_q) else $error("palette done without work");

endmodule

// File: tb/tb_mandelbrot_pixel_colour.sv
module tb_mandelbrot_pixel_colour;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 28;

	class colour_scoreboard;
		bit [63:0] width_r, height_r, aspect_r, zoom_r, escape_r, climit_r;
		mpc_pkg::pix_out_t expected_colours[$];
		int mismatches;
		int checked;
		int in_set_seen;

		function new();
			width_r = 1200;
			height_r = 800;
			aspect_r = 25165824;
			zoom_r = 25165824;
			escape_r = 50331648;
			climit_r = 40;
		endfunction

		function void set_reg(logic [2:0] idx, bit [31:0] val);
			case (idx)
				mpc_pkg::REG_WIDTH: begin
					width_r = val & 32'h1fff;
				end
				mpc_pkg::REG_HEIGHT: begin
					height_r = val & 32'h1fff;
				end
				mpc_pkg::REG_ASPECT: begin
					aspect_r = val;
				end
				mpc_pkg::REG_ZOOM: begin
					zoom_r = val;
				end
				mpc_pkg::REG_ESCAPE: begin
					escape_r = val;
				end
				mpc_pkg::REG_CLIMIT: begin
					climit_r = val & 32'h7f;
				end
				default: begin
				end
			endcase
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		function bit [63:0] magn(longint v);
			return v < 0 ? 64'd0 - 64'(v) : 64'(v);
		endfunction

		// product shifted right, truncated toward zero
		function longint fx_mul(longint a, longint b, int sh);
			bit neg;
			bit [63:0] p;
			longint r;
			neg = (a < 0) != (b < 0);
			p = (magn(a) * magn(b)) >> sh;
			r = longint'(p & 64'h7fffffffffffffff);
			return neg ? -r : r;
		endfunction

		function longint axis_frac(bit [63:0] p, bit [63:0] dim);
			longint num;
			num = (longint'(p) - 1) * (64'sd1 <<< FB);
			if (dim < 2)
				return 0;
			return clamp32(num / (longint'(dim) - 1));
		endfunction

		function mpc_pkg::pix_out_t predict_colour(mpc_pkg::pix_in_t pix);
			mpc_pkg::pix_out_t res;
			longint fx, fy, cre, cim, re, im, rr, ii, ri;
			bit [63:0] lim, quad, n, lc, seg, rem, qn, b, g, r;
			bit black;
			lim = escape_r << (FB - 24);
			fx = axis_frac(pix.pixel_x, width_r);
			fy = axis_frac(pix.pixel_y, height_r);
			cre = clamp32(fx_mul(longint'(aspect_r), fx, 24) - (64'sd1 <<< FB));
			cre = clamp32(fx_mul(longint'(zoom_r), cre, 24));
			cim = clamp32((64'sd1 <<< (FB - 1)) - fy);
			cim = clamp32(fx_mul(longint'(zoom_r), cim, 24));
			re = 0;
			im = 0;
			quad = 0;
			n = 1;
			lc = climit_r;
			b = 0;
			g = 0;
			r = 0;
			// escape test uses |z|^2 from before the update
			while (n < lc && quad < lim) begin
				rr = fx_mul(re, re, FB);
				ii = fx_mul(im, im, FB);
				ri = fx_mul(re, im, FB - 1);
				quad = (magn(re) * magn(re) + magn(im) * magn(im)) >> FB;
				re = clamp32(rr - ii + cre);
				im = clamp32(ri + cim);
				n++;
			end
			black = (n == lc);
			if (!black && lc != 0) begin
				seg = (7 * n) / lc;
				rem = (7 * n) % lc;
				qn = lc - rem;
				case (seg)
					0: begin
						g = rem * 255 / lc;
						b = rem * 127 / lc + 128;
					end
					1: begin
						r = rem * 255 / lc;
						g = 255;
						b = 255;
					end
					2: begin
						r = 255;
						g = 255;
						b = qn * 255 / lc;
					end
					3: begin
						r = 255;
						g = qn * 127 / lc + 128;
					end
					4: begin
						r = qn * 127 / lc + 128;
						g = qn * 63 / lc + 64;
					end
					5: begin
						r = 128;
						g = 64;
						b = rem * 128 / lc;
					end
					6: begin
						r = qn * 128 / lc;
						g = qn * 64 / lc;
						b = 128;
					end
					default: begin
					end
				endcase
			end
			res.blue = b[7:0];
			res.green = g[7:0];
			res.red = r[7:0];
			res.iteration_count = n[6:0];
			res.in_set = black;
			return res;
		endfunction

		function void note_pixel(mpc_pkg::pix_in_t pix);
			expected_colours.push_back(predict_colour(pix));
		endfunction

		function void check_colour(mpc_pkg::pix_out_t got);
			mpc_pkg::pix_out_t exp_c;
			checked++;
			if (expected_colours.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %p", got);
				return;
			end
			exp_c = expected_colours.pop_front();
			in_set_seen += exp_c.in_set;
			if (got !== exp_c) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: colour mismatch exp b%0d g%0d r%0d n%0d s%0d got b%0d g%0d r%0d n%0d s%0d",
						exp_c.blue, exp_c.green, exp_c.red, exp_c.iteration_count, exp_c.in_set,
						got.blue, got.green, got.red, got.iteration_count, got.in_set);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	mpc_pkg::pix_in_t in_data;
	logic out_valid;
	logic out_ready;
	mpc_pkg::pix_out_t out_data;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	colour_scoreboard sb;
	bit burst;
	int pixels_sent;
	int phases;

	mandelbrot_pixel_colour u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("mandelbrot_pixel_colour test failed");
		$finish;
	end

	// result side: random stall before each item, none in burst mode
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_colour(out_data);
		end
	end

	task automatic cfg_put(logic [2:0] idx, bit [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(bit [31:0] w, bit [31:0] h, bit [31:0] a, bit [31:0] z,
			bit [31:0] e, bit [31:0] c);
		cfg_put(mpc_pkg::REG_WIDTH, w);
		cfg_put(mpc_pkg::REG_HEIGHT, h);
		cfg_put(mpc_pkg::REG_ASPECT, a);
		cfg_put(mpc_pkg::REG_ZOOM, z);
		cfg_put(mpc_pkg::REG_ESCAPE, e);
		cfg_put(mpc_pkg::REG_CLIMIT, c);
		cfg_we <= 1'b0;
		phases++;
	endtask

	task automatic send_pixel(bit [12:0] x, bit [12:0] y);
		mpc_pkg::pix_in_t pix;
		int gap;
		pix.pixel_x = x;
		pix.pixel_y = y;
		gap = burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= pix;
		do @(posedge clk); while (!in_ready);
		sb.note_pixel(pix);
		pixels_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_colours.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_pixels(int count);
		bit [12:0] x, y;
		int wmax, hmax;
		wmax = sb.width_r < 1 ? 1 : int'(sb.width_r);
		hmax = sb.height_r < 1 ? 1 : int'(sb.height_r);
		repeat (count) begin
			if ($urandom_range(0, 9) < 8) begin
				x = 13'($urandom_range(1, wmax));
				y = 13'($urandom_range(1, hmax));
			end else begin
				x = 13'($urandom());
				y = 13'($urandom());
			end
			send_pixel(x, y);
		end
	endtask

	initial begin
		bit [31:0] w, h;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = mpc_pkg::REG_WIDTH;
		cfg_data = '0;
		burst = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration, corners and out-of-range coordinates
		send_pixel(1, 1);
		send_pixel(4096, 4096);
		send_pixel(1, 4096);
		send_pixel(4096, 1);
		send_pixel(600, 400);
		send_pixel(0, 0);
		send_pixel(8191, 8191);
		send_pixel(13'h0aaa, 13'h1555);
		send_pixel(13'h1555, 13'h0aaa);
		drain();

		// degenerate sizes, zero scale, colour limit 0 and 1
		configure(0, 1, 0, 0, 0, 0);
		send_pixel(5, 7);
		send_pixel(0, 0);
		drain();
		configure(1, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1);
		send_pixel(1, 1);
		send_pixel(8191, 0);
		drain();
		// saturated orbit with huge escape bound and the largest cap
		configure(2, 2, 32'hffffffff, 32'hffffffff, 32'hffffffff, 127);
		send_pixel(1, 1);
		send_pixel(2, 2);
		send_pixel(8191, 8191);
		drain();
		configure(8191, 8191, 25165824, 25165824, 50331648, 2);
		send_pixel(4096, 4096);
		send_pixel(8191, 1);
		send_pixel(1, 8191);
		drain();
		configure(4096, 4096, 25165824, 16777216, 67108864, 127);
		send_pixel(1024, 2048);
		send_pixel(2048, 2048);
		send_pixel(3000, 1500);
		drain();

		while (pixels_sent < 1200) begin
			burst = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0: begin
					w = $urandom_range(2, 64);
					h = $urandom_range(2, 64);
				end
				1: begin
					w = $urandom_range(2, 4096);
					h = $urandom_range(2, 4096);
				end
				2: begin
					w = $urandom_range(0, 8191);
					h = $urandom_range(0, 8191);
				end
				default: begin
					w = 1200;
					h = 800;
				end
			endcase
			if ($urandom_range(0, 4) == 0)
				configure(w, h, $urandom(), $urandom(), $urandom(), $urandom_range(0, 127));
			else
				configure(w, h, $urandom_range(16777216, 33554432),
					$urandom_range(8388608, 50331648), $urandom_range(16777216, 134217728),
					$urandom_range(2, 127));
			random_pixels($urandom_range(40, 120));
			drain();
		end
		burst = 1'b0;
		drain();

		$display("Checked %0d pixels (%0d in the set) over %0d register settings.",
			sb.checked, sb.in_set_seen, phases);
		if (sb.mismatches == 0 && sb.expected_colours.size() == 0)
			$display("mandelbrot_pixel_colour test passed");
		else
			$display("mandelbrot_pixel_colour test failed");
		$finish;
	end
endmodule
